[hdl/efd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants of the earliest-finish task dispatcher.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int ACTIVE_W     = 4;
    localparam int TYPES_W      = 16;
    localparam int TYPE_FIELD_W = 2;
    localparam int MASK_PORT_W  = 8;
    localparam int TIME_PORT_W  = 32;
    localparam int PROC_PORT_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PROCESSORS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROCESSOR_TYPES   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

[hdl/efd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_front
// Takes task requests, clamps times, folds the active count into the
// permitted mask and pushes the packed task into the queue.
// ----------------------------------------------------------------------------
module efd_front #(
    parameter int MAX_PROCESSORS = 8,
    parameter int TYPE_COUNT     = 4,
    parameter int TIME_BITS      = 32,
    parameter int ENTRY_W        = 1 + TIME_BITS + MAX_PROCESSORS + TYPE_COUNT * TIME_BITS
) (
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_restart,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_earliest_start,
    input  logic [efd_pkg::MASK_PORT_W-1:0]     i_allowed_mask,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type0,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type1,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type2,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type3,
    input  logic [efd_pkg::ACTIVE_W-1:0]        i_active_processors,
    input  efd_pkg::t_queue_status              i_queue_status,
    output logic                                o_busy,
    output logic                                o_push,
    output logic [ENTRY_W-1:0]                  o_entry
);

    localparam int EXEC_W = TYPE_COUNT * TIME_BITS;
    localparam logic [efd_pkg::TIME_PORT_W-1:0] TMAX32 =
        efd_pkg::TIME_PORT_W'((64'd1 << TIME_BITS) - 64'd1);

    function automatic logic [TIME_BITS-1:0] f_clamp(input logic [efd_pkg::TIME_PORT_W-1:0] v);
        logic [TIME_BITS-1:0] r;
        r = (v > TMAX32) ? TMAX32[TIME_BITS-1:0] : v[TIME_BITS-1:0];
        return r;
    endfunction

    logic [efd_pkg::TIME_PORT_W-1:0] w_exec_in [4];
    logic [MAX_PROCESSORS-1:0]       w_active_mask;

    assign w_exec_in[0] = i_exec_time_type0;
    assign w_exec_in[1] = i_exec_time_type1;
    assign w_exec_in[2] = i_exec_time_type2;
    assign w_exec_in[3] = i_exec_time_type3;

    genvar g;
    generate
        for (g = 0; g < MAX_PROCESSORS; g++) begin : g_act
            assign w_active_mask[g] = (i_active_processors > efd_pkg::ACTIVE_W'(g));
        end
        for (g = 0; g < TYPE_COUNT; g++) begin : g_exec
            assign o_entry[g*TIME_BITS +: TIME_BITS] = f_clamp(w_exec_in[g]);
        end
    endgenerate

    assign o_entry[EXEC_W +: MAX_PROCESSORS] =
        i_allowed_mask[MAX_PROCESSORS-1:0] & w_active_mask;
    assign o_entry[EXEC_W + MAX_PROCESSORS +: TIME_BITS] = f_clamp(i_earliest_start);
    assign o_entry[ENTRY_W-1] = i_restart;

    assign o_busy = i_queue_status.full || !i_rst_n;
    assign o_push = i_start && !o_busy;

endmodule

[hdl/efd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_queue
// Two-entry task queue between the front and the back.
// ----------------------------------------------------------------------------
module efd_queue #(
    parameter int DATA_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [DATA_W-1:0]       i_push_data,
    input  logic                    i_pop,
    output logic [DATA_W-1:0]       o_pop_data,
    output efd_pkg::t_queue_status  o_status
);

    logic [DATA_W-1:0] r_slot [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign w_do_push = i_push && !o_status.full;
    assign w_do_pop  = i_pop && !o_status.empty;
    assign o_pop_data = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_do_push) - 2'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

[hdl/efd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_back
// Scans one processor per cycle for the earliest finish, updates the
// ready times and issues the result strobe.
// ----------------------------------------------------------------------------
module efd_back #(
    parameter int MAX_PROCESSORS = 8,
    parameter int TYPE_COUNT     = 4,
    parameter int TIME_BITS      = 32,
    parameter int ENTRY_W        = 1 + TIME_BITS + MAX_PROCESSORS + TYPE_COUNT * TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [efd_pkg::TYPES_W-1:0]         i_processor_types,
    input  efd_pkg::t_queue_status              i_queue_status,
    input  logic [ENTRY_W-1:0]                  i_entry,
    output logic                                o_pop,
    output logic                                o_done,
    output logic [efd_pkg::PROC_PORT_W-1:0]     o_chosen_processor,
    output logic [efd_pkg::TIME_PORT_W-1:0]     o_start_at,
    output logic [efd_pkg::TIME_PORT_W-1:0]     o_finish_at,
    output logic                                o_no_processor
);

    localparam int EXEC_W = TYPE_COUNT * TIME_BITS;
    localparam int P_W    = $clog2(MAX_PROCESSORS);
    localparam int TI_W   = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam logic [P_W-1:0] LAST_P = P_W'(MAX_PROCESSORS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    efd_pkg::t_back_state r_state, n_state;

    logic [TIME_BITS-1:0]      r_ready [MAX_PROCESSORS];
    logic [TIME_BITS-1:0]      n_ready [MAX_PROCESSORS];
    logic [TIME_BITS-1:0]      r_exec  [TYPE_COUNT];
    logic [TIME_BITS-1:0]      n_exec  [TYPE_COUNT];
    logic [TIME_BITS-1:0]      r_es, n_es;
    logic [MAX_PROCESSORS-1:0] r_mask, n_mask;
    logic [P_W-1:0]            r_p, n_p;
    logic                      r_found, n_found;
    logic [P_W-1:0]            r_best_p, n_best_p;
    logic [TIME_BITS-1:0]      r_best_start, n_best_start;
    logic [TIME_BITS-1:0]      r_best_finish, n_best_finish;

    logic                                r_done, n_done;
    logic [efd_pkg::PROC_PORT_W-1:0]     r_chosen, n_chosen;
    logic [efd_pkg::TIME_PORT_W-1:0]     r_start_at, n_start_at;
    logic [efd_pkg::TIME_PORT_W-1:0]     r_finish_at, n_finish_at;
    logic                                r_no_proc, n_no_proc;

    logic [efd_pkg::TYPE_FIELD_W-1:0] w_type_raw;
    logic [TI_W-1:0]                  w_type;
    logic [TIME_BITS-1:0]             w_ready;
    logic [TIME_BITS-1:0]             w_start;
    logic [TIME_BITS:0]               w_sum;
    logic [TIME_BITS-1:0]             w_finish;

    // candidate for the processor under scan
    always_comb begin
        w_type_raw = i_processor_types[{r_p, 1'b0} +: efd_pkg::TYPE_FIELD_W];
        w_type     = ({1'b0, w_type_raw} >= 3'(TYPE_COUNT)) ? TI_W'(TYPE_COUNT - 1)
                                                            : TI_W'(w_type_raw);
        w_ready    = r_ready[r_p];
        w_start    = (w_ready > r_es) ? w_ready : r_es;
        w_sum      = {1'b0, w_start} + {1'b0, r_exec[w_type]};
        w_finish   = w_sum[TIME_BITS] ? TIME_MAX : w_sum[TIME_BITS-1:0];
    end

    always_comb begin
        n_state       = r_state;
        n_ready       = r_ready;
        n_exec        = r_exec;
        n_es          = r_es;
        n_mask        = r_mask;
        n_p           = r_p;
        n_found       = r_found;
        n_best_p      = r_best_p;
        n_best_start  = r_best_start;
        n_best_finish = r_best_finish;
        n_done        = 1'b0;
        n_chosen      = r_chosen;
        n_start_at    = r_start_at;
        n_finish_at   = r_finish_at;
        n_no_proc     = r_no_proc;
        o_pop         = 1'b0;
        case (r_state)
            efd_pkg::ST_IDLE: begin
                if (!i_queue_status.empty) begin
                    o_pop = 1'b1;
                    for (int t = 0; t < TYPE_COUNT; t++) begin
                        n_exec[t] = i_entry[t*TIME_BITS +: TIME_BITS];
                    end
                    n_mask        = i_entry[EXEC_W +: MAX_PROCESSORS];
                    n_es          = i_entry[EXEC_W + MAX_PROCESSORS +: TIME_BITS];
                    n_p           = '0;
                    n_found       = 1'b0;
                    n_best_p      = '0;
                    n_best_start  = '0;
                    n_best_finish = '0;
                    if (i_entry[ENTRY_W-1]) begin
                        for (int p = 0; p < MAX_PROCESSORS; p++) begin
                            n_ready[p] = '0;
                        end
                    end
                    n_state = efd_pkg::ST_SCAN;
                end
            end
            efd_pkg::ST_SCAN: begin
                if (r_mask[r_p] && (!r_found || (w_finish < r_best_finish))) begin
                    n_found       = 1'b1;
                    n_best_p      = r_p;
                    n_best_start  = w_start;
                    n_best_finish = w_finish;
                end
                if (r_p == LAST_P) begin
                    n_state = efd_pkg::ST_RESULT;
                end else begin
                    n_p = r_p + P_W'(1);
                end
            end
            efd_pkg::ST_RESULT: begin
                n_done = 1'b1;
                if (r_found) begin
                    n_ready[r_best_p] = r_best_finish;
                    n_chosen    = efd_pkg::PROC_PORT_W'(r_best_p);
                    n_start_at  = efd_pkg::TIME_PORT_W'(r_best_start);
                    n_finish_at = efd_pkg::TIME_PORT_W'(r_best_finish);
                    n_no_proc   = 1'b0;
                end else begin
                    n_chosen    = '0;
                    n_start_at  = '0;
                    n_finish_at = '0;
                    n_no_proc   = 1'b1;
                end
                n_state = efd_pkg::ST_IDLE;
            end
            default: begin
                n_state = efd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efd_pkg::ST_IDLE;
            r_done  <= 1'b0;
            for (int p = 0; p < MAX_PROCESSORS; p++) begin
                r_ready[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_ready <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exec        <= n_exec;
        r_es          <= n_es;
        r_mask        <= n_mask;
        r_p           <= n_p;
        r_found       <= n_found;
        r_best_p      <= n_best_p;
        r_best_start  <= n_best_start;
        r_best_finish <= n_best_finish;
        r_chosen      <= n_chosen;
        r_start_at    <= n_start_at;
        r_finish_at   <= n_finish_at;
        r_no_proc     <= n_no_proc;
    end

    assign o_done             = r_done;
    assign o_chosen_processor = r_chosen;
    assign o_start_at         = r_start_at;
    assign o_finish_at        = r_finish_at;
    assign o_no_processor     = r_no_proc;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_no_processor) |->
            (o_chosen_processor == '0 && o_start_at == '0 && o_finish_at == '0))
        else $error("fields not zero without a processor");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_start_at <= o_finish_at))
        else $error("finish before start");

    a_ready_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efd_pkg::ST_RESULT && r_found) |=> (r_ready[$past(r_best_p)] == $past(r_best_finish)))
        else $error("ready time not updated");

endmodule

[hdl/earliest_finish_task_dispatcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_finish_task_dispatcher
// Earliest-finish-time list scheduler: picks the permitted processor with the
// smallest finish time and books the task on it.
//
//   channel   ports                                   handshake
//   task      i_restart .. i_exec_time_type3          start, busy
//   result    o_chosen_processor .. o_no_processor    o_done strobe
//   config    i_cfg_index, i_cfg_data                 i_cfg_we
//
// In the back end a task is loaded from the queue, then scanned one processor
// per cycle through the shared add and compare, then resolved in a result state.
// A two-entry queue lets up to two tasks wait while one is scanned.
// Reset is synchronous, active low; ready times clear at once, busy is high.
// The o_done strobe is high for a single cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module earliest_finish_task_dispatcher #(
    parameter int MAX_PROCESSORS = 8,
    parameter int TYPE_COUNT     = 4,
    parameter int TIME_BITS      = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_restart,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_earliest_start,
    input  logic [efd_pkg::MASK_PORT_W-1:0]     i_allowed_mask,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type0,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type1,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type2,
    input  logic [efd_pkg::TIME_PORT_W-1:0]     i_exec_time_type3,
    output logic                                o_done,
    output logic [efd_pkg::PROC_PORT_W-1:0]     o_chosen_processor,
    output logic [efd_pkg::TIME_PORT_W-1:0]     o_start_at,
    output logic [efd_pkg::TIME_PORT_W-1:0]     o_finish_at,
    output logic                                o_no_processor,
    input  logic                                i_cfg_we,
    input  logic [efd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ENTRY_W = 1 + TIME_BITS + MAX_PROCESSORS + TYPE_COUNT * TIME_BITS;

    logic [efd_pkg::ACTIVE_W-1:0] r_active_processors;
    logic [efd_pkg::TYPES_W-1:0]  r_processor_types;

    efd_pkg::t_queue_status w_queue_status;
    logic                   w_push;
    logic                   w_pop;
    logic [ENTRY_W-1:0]     w_push_entry;
    logic [ENTRY_W-1:0]     w_pop_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_processors <= efd_pkg::ACTIVE_W'(8);
            r_processor_types   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                efd_pkg::REG_ACTIVE_PROCESSORS: begin
                    r_active_processors <= i_cfg_data[efd_pkg::ACTIVE_W-1:0];
                end
                efd_pkg::REG_PROCESSOR_TYPES: begin
                    r_processor_types <= i_cfg_data[efd_pkg::TYPES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    efd_front #(
        .MAX_PROCESSORS (MAX_PROCESSORS),
        .TYPE_COUNT     (TYPE_COUNT),
        .TIME_BITS      (TIME_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_front (
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_restart           (i_restart),
        .i_earliest_start    (i_earliest_start),
        .i_allowed_mask      (i_allowed_mask),
        .i_exec_time_type0   (i_exec_time_type0),
        .i_exec_time_type1   (i_exec_time_type1),
        .i_exec_time_type2   (i_exec_time_type2),
        .i_exec_time_type3   (i_exec_time_type3),
        .i_active_processors (r_active_processors),
        .i_queue_status      (w_queue_status),
        .o_busy              (busy),
        .o_push              (w_push),
        .o_entry             (w_push_entry)
    );

    efd_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_entry),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_entry),
        .o_status    (w_queue_status)
    );

    efd_back #(
        .MAX_PROCESSORS (MAX_PROCESSORS),
        .TYPE_COUNT     (TYPE_COUNT),
        .TIME_BITS      (TIME_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_processor_types  (r_processor_types),
        .i_queue_status     (w_queue_status),
        .i_entry            (w_pop_entry),
        .o_pop              (w_pop),
        .o_done             (o_done),
        .o_chosen_processor (o_chosen_processor),
        .o_start_at         (o_start_at),
        .o_finish_at        (o_finish_at),
        .o_no_processor     (o_no_processor)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the earliest-finish task dispatcher. A directed
// table covers the corner cases (no permitted processor, saturation, ties,
// active counts of zero and above the maximum), then randomized requests run
// through several register settings. Each result is checked against its row's
// fixed result or a bench copy of processor ready times and the dispatch rule.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_PROCS   = 8;
    localparam int NUM_TYPES   = 4;
    localparam int BACK_CYCLES = NUM_PROCS + 2;
    localparam int CYCLE_LIMIT = 500000;

    typedef logic [efd_pkg::TIME_PORT_W-1:0] t_time;

    typedef struct packed {
        logic                               restart;
        t_time                              earliest_start;
        logic [efd_pkg::MASK_PORT_W-1:0]    allowed_mask;
        logic [NUM_TYPES-1:0][31:0]         exec_time;
    } t_task_req;

    typedef struct packed {
        logic [efd_pkg::PROC_PORT_W-1:0] chosen_processor;
        t_time                           start_at;
        t_time                           finish_at;
        logic                            no_processor;
    } t_dispatch;

    typedef struct {
        bit                              is_cfg;
        logic [efd_pkg::CFG_INDEX_W-1:0] cfg_index;
        logic [efd_pkg::CFG_DATA_W-1:0]  cfg_data;
        t_task_req                       req;
        bit                              has_fixed;
        t_dispatch                       fixed;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic                            i_restart;
    t_time                           i_earliest_start;
    logic [efd_pkg::MASK_PORT_W-1:0] i_allowed_mask;
    t_time                           i_exec_time_type0;
    t_time                           i_exec_time_type1;
    t_time                           i_exec_time_type2;
    t_time                           i_exec_time_type3;
    logic                            o_done;
    logic [efd_pkg::PROC_PORT_W-1:0] o_chosen_processor;
    t_time                           o_start_at;
    t_time                           o_finish_at;
    logic                            o_no_processor;
    logic                            i_cfg_we;
    logic [efd_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [efd_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // bench copy of the block state and registers
    t_time                         proc_ready [NUM_PROCS];
    logic [3:0]                    active_count_cfg;
    logic [efd_pkg::TYPES_W-1:0]   proc_types_cfg;

    t_dispatch   pending_dispatches [$];
    t_stim_row   directed_rows [$];
    int unsigned error_count;
    int unsigned cycle_count = 0;

    earliest_finish_task_dispatcher u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_restart          (i_restart),
        .i_earliest_start   (i_earliest_start),
        .i_allowed_mask     (i_allowed_mask),
        .i_exec_time_type0  (i_exec_time_type0),
        .i_exec_time_type1  (i_exec_time_type1),
        .i_exec_time_type2  (i_exec_time_type2),
        .i_exec_time_type3  (i_exec_time_type3),
        .o_done             (o_done),
        .o_chosen_processor (o_chosen_processor),
        .o_start_at         (o_start_at),
        .o_finish_at        (o_finish_at),
        .o_no_processor     (o_no_processor),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input t_time got, input t_time want);
        $display("%0t: mismatch %s: got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // books the request on the best processor and returns the dispatch
    function automatic t_dispatch book_task(input t_task_req req);
        t_dispatch   res;
        bit          found;
        int          count;
        logic [1:0]  ptype;
        t_time       cand_start;
        t_time       cand_finish;
        logic [32:0] sum;
        res   = '0;
        found = 1'b0;
        if (req.restart) begin
            for (int p = 0; p < NUM_PROCS; p++) proc_ready[p] = '0;
        end
        count = (active_count_cfg > NUM_PROCS) ? NUM_PROCS : int'(active_count_cfg);
        for (int p = 0; p < NUM_PROCS; p++) begin
            if (p < count && req.allowed_mask[p]) begin
                ptype       = proc_types_cfg[2*p +: 2];
                cand_start  = (proc_ready[p] > req.earliest_start) ?
                              proc_ready[p] : req.earliest_start;
                sum         = {1'b0, cand_start} + {1'b0, req.exec_time[ptype]};
                cand_finish = sum[32] ? '1 : sum[31:0];
                if (!found || cand_finish < res.finish_at) begin
                    found                = 1'b1;
                    res.chosen_processor = efd_pkg::PROC_PORT_W'(p);
                    res.start_at         = cand_start;
                    res.finish_at        = cand_finish;
                end
            end
        end
        if (found) proc_ready[res.chosen_processor] = res.finish_at;
        else res.no_processor = 1'b1;
        return res;
    endfunction

    function automatic t_stim_row cfg_row(input logic [efd_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [efd_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_data  = data;
        return row;
    endfunction

    function automatic t_stim_row req_row(input logic rs, input t_time es,
                                          input logic [7:0] mask, input t_time e0,
                                          input t_time e1, input t_time e2,
                                          input t_time e3);
        t_stim_row row;
        row                    = '{default: '0};
        row.req.restart        = rs;
        row.req.earliest_start = es;
        row.req.allowed_mask   = mask;
        row.req.exec_time      = {e3, e2, e1, e0};
        return row;
    endfunction

    function automatic t_stim_row with_result(input t_stim_row row, input logic [2:0] proc,
                                              input t_time st, input t_time fin,
                                              input logic none);
        row.has_fixed = 1'b1;
        row.fixed     = '{proc, st, fin, none};
        return row;
    endfunction

    function automatic t_task_req random_request();
        t_task_req r;
        r.restart = ($urandom_range(99) < 4);
        case ($urandom_range(9))
            0:       r.earliest_start = '0;
            1:       r.earliest_start = $urandom;
            2:       r.earliest_start = '1;
            default: r.earliest_start = proc_ready[3'($urandom_range(NUM_PROCS - 1))]
                                        + $urandom_range(60);
        endcase
        case ($urandom_range(9))
            0:       r.allowed_mask = '0;
            1:       r.allowed_mask = '1;
            default: r.allowed_mask = 8'($urandom_range(255));
        endcase
        for (int t = 0; t < NUM_TYPES; t++) begin
            case ($urandom_range(19))
                0:       r.exec_time[t] = $urandom;
                1:       r.exec_time[t] = '1;
                2:       r.exec_time[t] = '0;
                default: r.exec_time[t] = $urandom_range(1, 200);
            endcase
        end
        return r;
    endfunction

    task automatic write_config(input logic [efd_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [efd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx == efd_pkg::REG_ACTIVE_PROCESSORS) active_count_cfg = data[3:0];
        else proc_types_cfg = data;
    endtask

    // holds the request and leaves start high once it is taken
    task automatic send_request(input t_task_req req, input bit has_fixed,
                                input t_dispatch fixed);
        t_dispatch predicted;
        @(negedge i_clk);
        start             = 1'b1;
        i_restart         = req.restart;
        i_earliest_start  = req.earliest_start;
        i_allowed_mask    = req.allowed_mask;
        i_exec_time_type0 = req.exec_time[0];
        i_exec_time_type1 = req.exec_time[1];
        i_exec_time_type2 = req.exec_time[2];
        i_exec_time_type3 = req.exec_time[3];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = book_task(req);
        pending_dispatches.push_back(has_fixed ? fixed : predicted);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_dispatches.size() != 0) @(posedge i_clk);
        repeat (BACK_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_dispatch want;
        if (i_rst_n && o_done) begin
            if (pending_dispatches.size() == 0) begin
                report_mismatch("unexpected result", o_finish_at, '0);
            end else begin
                want = pending_dispatches.pop_front();
                if (o_chosen_processor !== want.chosen_processor)
                    report_mismatch("chosen_processor", t_time'(o_chosen_processor),
                                    t_time'(want.chosen_processor));
                if (o_start_at !== want.start_at)
                    report_mismatch("start_at", o_start_at, want.start_at);
                if (o_finish_at !== want.finish_at)
                    report_mismatch("finish_at", o_finish_at, want.finish_at);
                if (o_no_processor !== want.no_processor)
                    report_mismatch("no_processor", t_time'(o_no_processor),
                                    t_time'(want.no_processor));
            end
        end
    end

    initial begin
        int unsigned                 phase_count [8];
        logic [3:0]                  phase_active [8];
        logic [efd_pkg::TYPES_W-1:0] phase_types;
        t_dispatch                   none_fixed;

        phase_count  = '{300, 250, 250, 40, 250, 250, 250, 360};
        phase_active = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5, 4'd8};
        none_fixed   = '0;

        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_restart         = 1'b0;
        i_earliest_start  = '0;
        i_allowed_mask    = '0;
        i_exec_time_type0 = '0;
        i_exec_time_type1 = '0;
        i_exec_time_type2 = '0;
        i_exec_time_type3 = '0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = efd_pkg::REG_ACTIVE_PROCESSORS;
        i_cfg_data        = '0;
        error_count       = 0;
        active_count_cfg  = 4'd8;
        proc_types_cfg    = '0;
        for (int p = 0; p < NUM_PROCS; p++) proc_ready[p] = '0;

        // reset values: all type 0, eight active
        directed_rows.push_back(with_result(req_row(1'b1, '0, 8'hFF, '0, '1, '1, '1),
                                            3'd0, '0, '0, 1'b0));
        directed_rows.push_back(with_result(req_row(1'b0, '0, 8'hFF, 32'd5, '0, '0, '0),
                                            3'd0, '0, 32'd5, 1'b0));
        directed_rows.push_back(with_result(req_row(1'b0, '0, 8'h00, 32'd1, '0, '0, '0),
                                            3'd0, '0, '0, 1'b1));
        // saturation on all processors, tie to lowest index
        directed_rows.push_back(with_result(req_row(1'b0, '1, 8'hFF, '1, '1, '1, '1),
                                            3'd0, '1, '1, 1'b0));
        // saturated processor still chosen
        directed_rows.push_back(with_result(req_row(1'b0, '0, 8'h01, 32'd1, '0, '0, '0),
                                            3'd0, '1, '1, 1'b0));
        directed_rows.push_back(with_result(req_row(1'b1, 32'd10, 8'h80, 32'd3, '1, '1, '1),
                                            3'd7, 32'd10, 32'd13, 1'b0));
        directed_rows.push_back(cfg_row(efd_pkg::REG_PROCESSOR_TYPES, 16'hFFFF));
        directed_rows.push_back(req_row(1'b0, '0, 8'hFF, '0, '0, '0, 32'd7));
        directed_rows.push_back(cfg_row(efd_pkg::REG_ACTIVE_PROCESSORS, 16'd0));
        directed_rows.push_back(with_result(req_row(1'b0, '0, 8'hFF, 32'd1, 32'd1, 32'd1,
                                                    32'd1), 3'd0, '0, '0, 1'b1));
        // active count above the maximum
        directed_rows.push_back(cfg_row(efd_pkg::REG_ACTIVE_PROCESSORS, 16'd15));
        directed_rows.push_back(with_result(req_row(1'b1, '0, 8'h80, '1, '1, '1, 32'd2),
                                            3'd7, '0, 32'd2, 1'b0));
        // mask bits beyond the active count
        directed_rows.push_back(cfg_row(efd_pkg::REG_ACTIVE_PROCESSORS, 16'd1));
        directed_rows.push_back(with_result(req_row(1'b0, '0, 8'hFE, '0, '0, '0, '0),
                                            3'd0, '0, '0, 1'b1));
        directed_rows.push_back(req_row(1'b0, 32'h5555_5555, 8'hFF, '0, '0, '0, 32'd9));
        directed_rows.push_back(cfg_row(efd_pkg::REG_PROCESSOR_TYPES, 16'h00E4));
        directed_rows.push_back(cfg_row(efd_pkg::REG_ACTIVE_PROCESSORS, 16'd4));
        directed_rows.push_back(req_row(1'b1, '0, 8'h0F, 32'd40, 32'd30, 32'd20, 32'd10));
        directed_rows.push_back(req_row(1'b0, 32'hAAAA_AAAA, 8'h0F, 32'h5555_5555,
                                        32'hAAAA_AAAA, '1, '0));
        directed_rows.push_back(req_row(1'b1, '0, 8'hAA, '1, '1, '1, '1));
        directed_rows.push_back(req_row(1'b0, 32'd3, 8'h55, 32'd8, 32'd8, 32'd8, 32'd8));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_drained();
                write_config(directed_rows[k].cfg_index, directed_rows[k].cfg_data);
            end else begin
                send_request(directed_rows[k].req, directed_rows[k].has_fixed,
                             directed_rows[k].fixed);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                1:       phase_types = 16'hFFFF;
                4:       phase_types = 16'h0000;
                5:       phase_types = 16'h00E4;
                default: phase_types = 16'($urandom_range(16'hFFFF));
            endcase
            write_config(efd_pkg::REG_ACTIVE_PROCESSORS,
                         efd_pkg::CFG_DATA_W'(phase_active[ph]));
            write_config(efd_pkg::REG_PROCESSOR_TYPES, phase_types);
            for (int unsigned n = 0; n < phase_count[ph]; n++) begin
                if (ph == 0 && n == 150) wait_drained();
                // last phase runs back to back
                if (ph != 7 && $urandom_range(99) < 35)
                    idle_cycles($urandom_range(1, 12));
                send_request(random_request(), 1'b0, none_fixed);
            end
        end

        wait_drained();
        repeat (3 * BACK_CYCLES) @(posedge i_clk);
        if (pending_dispatches.size() != 0)
            report_mismatch("results never arrived", t_time'(pending_dispatches.size()), '0);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
